[rtl/vlw_pkg.sv]
`default_nettype none

package vlw_pkg;

  // Field widths of a line request and of an emitted point.
  localparam int XY_W = 9;
  localparam int Z_W = 6;
  localparam int PXY_W = XY_W + 1;
  localparam int PZ_W = Z_W + 1;

  // Fixed-point crossing times.
  localparam int UNIT_SHIFT = 9;
  localparam int QUO_W = XY_W + UNIT_SHIFT;
  localparam int T0_W = 20;
  localparam int TIME_W = 28;
  localparam logic [T0_W-1:0] TMAX_ALT = T0_W'(32'h3FFF_FFFF / 1024);
  localparam logic [T0_W-1:0] UNIT_TIME = T0_W'(512);

  // Highest coordinates; a step up from one of them ends the run at the bound.
  localparam logic signed [PXY_W-1:0] XY_TOP = PXY_W'(511);
  localparam logic signed [PZ_W-1:0] Z_TOP = PZ_W'(63);

  localparam int MAX_POINTS_DEF = 50;

  // Depth of the job queue between setup and walk.
  localparam int QDEPTH = 2;

  // Reason the run ended, carried on its last point.
  typedef enum logic [1:0] {
    CAUSE_END   = 2'd0,
    CAUSE_LIMIT = 2'd1,
    CAUSE_BOUND = 2'd2
  } cause_t;

  // One prepared walk: start, end, directions and initial crossing times.
  typedef struct packed {
    logic [XY_W-1:0] sx;
    logic [XY_W-1:0] sy;
    logic [Z_W-1:0]  sz;
    logic [XY_W-1:0] ex;
    logic [XY_W-1:0] ey;
    logic [Z_W-1:0]  ez;
    logic            neg_x;
    logic            neg_y;
    logic            neg_z;
    logic [T0_W-1:0] t0x;
    logic [T0_W-1:0] t0y;
    logic [T0_W-1:0] t0z;
  } job_t;

endpackage

`default_nettype wire

[rtl/vlw_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module vlw_div
  import vlw_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [QUO_W-1:0] dividend,
  input  wire logic [XY_W-1:0]  divisor,
  output logic                  done,
  output logic [QUO_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(QUO_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [XY_W:0]     rem;
  logic [QUO_W-1:0]  quo;
  logic [XY_W-1:0]   dsr;
  logic [XY_W:0]     rem_sh;
  logic              fits;

  // Trial subtraction of the shifted partial remainder.
  always_comb begin
    rem_sh = {rem[XY_W-1:0], quo[QUO_W-1]};
    fits = rem_sh >= {1'b0, dsr};
  end

  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(QUO_W - 1);
        rem <= '0;
        quo <= dividend;
        dsr <= divisor;
      end else if (busy) begin
        rem <= fits ? rem_sh - {1'b0, dsr} : rem_sh;
        quo <= {quo[QUO_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/vlw_front.sv]
`default_nettype none

// Accepts line requests, finds the major axis and computes crossing times.
module vlw_front
  import vlw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,
  input  wire logic        q_full,
  output logic             q_push,
  output job_t             q_job
);

  typedef enum logic [2:0] {
    F_IDLE, F_SEL, F_STA, F_WAITA, F_STB, F_WAITB, F_PUSH
  } fstate_t;

  typedef enum logic [1:0] {
    AX_X, AX_Y, AX_Z
  } axis_t;

  fstate_t state;
  axis_t major_ax;

  logic [XY_W-1:0] sx, sy, ex, ey;
  logic [Z_W-1:0]  sz, ez;
  logic            neg_x, neg_y, neg_z;
  logic [XY_W-1:0] ax, ay;
  logic [Z_W-1:0]  az;
  logic [XY_W-1:0] major, minor_a, minor_b;
  logic [T0_W-1:0] ta, tb;

  logic signed [XY_W:0] dx, dy;
  logic signed [Z_W:0]  dz;
  logic                 div_start, div_done;
  logic [QUO_W-1:0]     div_q;
  logic [T0_W-1:0]      t_cur;

  // Signed distances of the incoming request.
  always_comb begin
    dx = $signed({1'b0, s_tdata[32:24]}) - $signed({1'b0, s_tdata[8:0]});
    dy = $signed({1'b0, s_tdata[41:33]}) - $signed({1'b0, s_tdata[17:9]});
    dz = $signed({1'b0, s_tdata[47:42]}) - $signed({1'b0, s_tdata[23:18]});
  end

  assign s_tready = (state == F_IDLE);
  assign div_start = (state == F_STA) || (state == F_STB);
  assign q_push = (state == F_PUSH) && !q_full;

  vlw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({major, UNIT_SHIFT'(0)}),
    .divisor  ((state == F_STA) ? minor_a : minor_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // A zero minor distance never crosses, so it takes the large constant.
  always_comb begin
    if (state == F_WAITA) begin
      t_cur = (minor_a == '0) ? TMAX_ALT : T0_W'(div_q);
    end else begin
      t_cur = (minor_b == '0) ? TMAX_ALT : T0_W'(div_q);
    end
  end

  // Job record: the major axis gets the unit time, the others the quotients.
  always_comb begin
    q_job.sx = sx;
    q_job.sy = sy;
    q_job.sz = sz;
    q_job.ex = ex;
    q_job.ey = ey;
    q_job.ez = ez;
    q_job.neg_x = neg_x;
    q_job.neg_y = neg_y;
    q_job.neg_z = neg_z;
    case (major_ax)
      AX_X: begin
        q_job.t0x = UNIT_TIME;
        q_job.t0y = ta;
        q_job.t0z = tb;
      end
      AX_Y: begin
        q_job.t0x = ta;
        q_job.t0y = UNIT_TIME;
        q_job.t0z = tb;
      end
      default: begin
        q_job.t0x = ta;
        q_job.t0y = tb;
        q_job.t0z = UNIT_TIME;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (s_tvalid) begin
            sx <= s_tdata[8:0];
            sy <= s_tdata[17:9];
            sz <= s_tdata[23:18];
            ex <= s_tdata[32:24];
            ey <= s_tdata[41:33];
            ez <= s_tdata[47:42];
            neg_x <= dx[XY_W];
            neg_y <= dy[XY_W];
            neg_z <= dz[Z_W];
            ax <= dx[XY_W] ? XY_W'(-dx) : dx[XY_W-1:0];
            ay <= dy[XY_W] ? XY_W'(-dy) : dy[XY_W-1:0];
            az <= dz[Z_W] ? Z_W'(-dz) : dz[Z_W-1:0];
            state <= F_SEL;
          end
        end
        // Major axis: largest distance, ties go to x, then y.
        F_SEL: begin
          if (ax >= ay && ax >= XY_W'(az)) begin
            major_ax <= AX_X;
            major <= ax;
            minor_a <= ay;
            minor_b <= XY_W'(az);
          end else if (ay >= XY_W'(az)) begin
            major_ax <= AX_Y;
            major <= ay;
            minor_a <= ax;
            minor_b <= XY_W'(az);
          end else begin
            major_ax <= AX_Z;
            major <= XY_W'(az);
            minor_a <= ax;
            minor_b <= ay;
          end
          state <= F_STA;
        end
        F_STA: begin
          state <= F_WAITA;
        end
        F_WAITA: begin
          if (div_done) begin
            ta <= t_cur;
            state <= F_STB;
          end
        end
        F_STB: begin
          state <= F_WAITB;
        end
        F_WAITB: begin
          if (div_done) begin
            tb <= t_cur;
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/vlw_fifo.sv]
`default_nettype none

// Short job queue between setup and walk.
module vlw_fifo
  import vlw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output logic      full,
  output logic      empty,
  output job_t      head_job
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  job_t          mem [QDEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full = (count == CW'(QDEPTH));
  assign empty = (count == '0);
  assign head_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/vlw_back.sv]
`default_nettype none

// Walks one prepared line, one voxel per cycle while the output is not stalled, into an output register.
module vlw_back
  import vlw_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_empty,
  input  wire job_t        q_job,
  output logic             q_pop,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,
  output logic             m_tlast,
  output logic [1:0]       m_tuser
);

  localparam int CW = $clog2(MAX_POINTS + 1);

  logic                    busy;
  job_t                    job;
  logic signed [PXY_W-1:0] px, py;
  logic signed [PZ_W-1:0]  pz;
  logic [TIME_W-1:0]       tx, ty, tz;
  logic [CW-1:0]           count;

  logic signed [PXY_W-1:0] out_x, out_y;
  logic signed [PZ_W-1:0]  out_z;
  logic                    out_last;
  cause_t                  out_cause;

  logic   advance, at_end, at_limit, sel_z, sel_x, at_bound, last;
  cause_t cause;
  logic signed [PXY_W-1:0] step_x, step_y;
  logic signed [PZ_W-1:0]  step_z;

  assign q_pop = !busy && !q_empty;
  assign advance = busy && (!m_tvalid || m_tready);

  // Stop tests for the current point and choice of the next step.
  always_comb begin
    at_end = (px == $signed({1'b0, job.ex})) && (py == $signed({1'b0, job.ey}))
          && (pz == $signed({1'b0, job.ez}));
    at_limit = (count == CW'(MAX_POINTS - 1));
    sel_z = (tz <= tx) && (tz <= ty);
    sel_x = !sel_z && (tx < ty);
    if (sel_z) begin
      at_bound = !job.neg_z && (pz == Z_TOP);
    end else if (sel_x) begin
      at_bound = !job.neg_x && (px == XY_TOP);
    end else begin
      at_bound = !job.neg_y && (py == XY_TOP);
    end
    last = at_end || at_limit || at_bound;
    if (at_end) begin
      cause = CAUSE_END;
    end else if (at_limit) begin
      cause = CAUSE_LIMIT;
    end else begin
      cause = CAUSE_BOUND;
    end
    step_x = job.neg_x ? -PXY_W'(1) : PXY_W'(1);
    step_y = job.neg_y ? -PXY_W'(1) : PXY_W'(1);
    step_z = job.neg_z ? -PZ_W'(1) : PZ_W'(1);
  end

  // Walk state: load a job, then emit and step until the run ends.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      job <= q_job;
      px <= $signed({1'b0, q_job.sx});
      py <= $signed({1'b0, q_job.sy});
      pz <= $signed({1'b0, q_job.sz});
      tx <= TIME_W'(q_job.t0x);
      ty <= TIME_W'(q_job.t0y);
      tz <= TIME_W'(q_job.t0z);
      count <= '0;
    end else if (advance) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        count <= count + 1'b1;
        if (sel_z) begin
          pz <= pz + step_z;
          tz <= tz + TIME_W'({job.t0z, 1'b0});
        end else if (sel_x) begin
          px <= px + step_x;
          tx <= tx + TIME_W'({job.t0x, 1'b0});
        end else begin
          py <= py + step_y;
          ty <= ty + TIME_W'({job.t0y, 1'b0});
        end
      end
    end
  end

  // Output register: refilled during a walk whenever it is empty or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
      out_x <= px;
      out_y <= py;
      out_z <= pz;
      out_last <= last;
      out_cause <= last ? cause : CAUSE_END;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {5'd0, out_z, out_y, out_x};
  assign m_tlast = out_last;
  assign m_tuser = out_cause;

endmodule

`default_nettype wire

[rtl/voxel_line_walk_3d.sv]
`default_nettype none

// Channel  Dir  Payload
// s_*      in   s_tdata[47:0]: start_x, start_y, start_z, end_x, end_y, end_z
// m_*      out  m_tdata[31:0]: point_x, point_y, point_z; m_tlast: is_last;
//               m_tuser[1:0]: stop_cause
//
// Setup of one request runs two divisions on the shared bit-serial
// divider; then the walk emits one point per cycle while the output is
// not stalled, 1 to MAX_POINTS points. The job queue lets setup of
// the next request overlap the current walk. Reset clears all control
// state; a stalled output holds the walk in place without losing points.
module voxel_line_walk_3d
  import vlw_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // start_x, start_y, start_z, end_x, end_y, end_z
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // point_x, point_y, point_z, zero fill
  output logic             m_tlast,
  output logic [1:0]       m_tuser   // stop_cause
);

  logic q_full, q_empty, q_push, q_pop;
  job_t push_job, head_job;

  vlw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  vlw_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head_job (head_job)
  );

  vlw_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_job    (head_job),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;
  import vlw_pkg::*;

  localparam int WALK_MAX = MAX_POINTS_DEF;
  localparam int STALL_CYCLES = 400;
  localparam int SETTLE_CYCLES = 120;

  // One emitted voxel as the block should present it.
  typedef struct {
    logic [PXY_W-1:0] x;
    logic [PXY_W-1:0] y;
    logic [PZ_W-1:0]  z;
    logic             last;
    cause_t           cause;
  } voxel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;

  voxel_t voxel_q[$];

  // Shared run state.
  bit quiet = 1'b0;
  bit stall_req = 1'b0;
  int stall_left = 0;
  int mismatches = 0;
  int lines_sent = 0;
  int voxels_seen = 0;
  int runs_end = 0;
  int runs_limit = 0;
  int runs_bound = 0;

  voxel_line_walk_3d u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  // Crossing time of a minor axis, or the far-away time for a flat axis.
  function automatic int minor_cross(int major, int minor);
    if (minor == 0) begin
      return int'(TMAX_ALT);
    end
    return (major * int'(UNIT_TIME)) / minor;
  endfunction

  // Walk the line the way the block does and queue every voxel it emits.
  task automatic predict_walk(input int sx, input int sy, input int sz,
                              input int ex, input int ey, input int ez);
    int dx, dy, dz, ax, ay, az, stx, sty, stz;
    int tx, ty, tz, ix, iy, iz, px, py, pz, count;
    voxel_t v;
    cause_t why;
    begin
      dx = ex - sx;
      dy = ey - sy;
      dz = ez - sz;
      stx = (dx < 0) ? -1 : 1;
      sty = (dy < 0) ? -1 : 1;
      stz = (dz < 0) ? -1 : 1;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      az = (dz < 0) ? -dz : dz;
      if (ax >= ay && ax >= az) begin
        tx = int'(UNIT_TIME);
        ty = minor_cross(ax, ay);
        tz = minor_cross(ax, az);
      end else if (ay >= az) begin
        tx = minor_cross(ay, ax);
        ty = int'(UNIT_TIME);
        tz = minor_cross(ay, az);
      end else begin
        tx = minor_cross(az, ax);
        ty = minor_cross(az, ay);
        tz = int'(UNIT_TIME);
      end
      ix = 2 * tx;
      iy = 2 * ty;
      iz = 2 * tz;
      px = sx;
      py = sy;
      pz = sz;
      count = 0;
      forever begin
        v.x = px[PXY_W-1:0];
        v.y = py[PXY_W-1:0];
        v.z = pz[PZ_W-1:0];
        v.last = 1'b0;
        v.cause = CAUSE_END;
        voxel_q.push_back(v);
        count++;
        if (px == ex && py == ey && pz == ez) begin
          why = CAUSE_END;
          break;
        end
        if (count >= WALK_MAX) begin
          why = CAUSE_LIMIT;
          break;
        end
        // Z wins ties, then x only when strictly earlier than y.
        if (tz <= tx && tz <= ty) begin
          if (pz + stz > int'(Z_TOP)) begin
            why = CAUSE_BOUND;
            break;
          end
          pz += stz;
          tz += iz;
        end else if (tx < ty) begin
          if (px + stx > int'(XY_TOP)) begin
            why = CAUSE_BOUND;
            break;
          end
          px += stx;
          tx += ix;
        end else begin
          if (py + sty > int'(XY_TOP)) begin
            why = CAUSE_BOUND;
            break;
          end
          py += sty;
          ty += iy;
        end
      end
      voxel_q[voxel_q.size()-1].last = 1'b1;
      voxel_q[voxel_q.size()-1].cause = why;
    end
  endtask

  // Offer one line request and hold it until the transfer completes.
  task automatic send_line(input int sx, input int sy, input int sz,
                           input int ex, input int ey, input int ez);
    logic [47:0] word;
    begin
      word = {ez[Z_W-1:0], ey[XY_W-1:0], ex[XY_W-1:0],
              sz[Z_W-1:0], sy[XY_W-1:0], sx[XY_W-1:0]};
      predict_walk(sx, sy, sz, ex, ey, ez);
      if (!quiet && $urandom_range(99) < 37) begin
        s_tvalid <= 1'b0;
        do begin
          @(posedge clk);
        end while (!quiet && $urandom_range(99) < 37);
      end
      s_tvalid <= 1'b1;
      s_tdata <= word;
      @(posedge clk);
      while (!s_tready) begin
        @(posedge clk);
      end
      lines_sent++;
    end
  endtask

  // Stop offering, then wait for every queued voxel and a little beyond.
  task automatic drain;
    begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while (voxel_q.size() != 0) begin
        @(posedge clk);
      end
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
  endtask

  // Clamp a coordinate into its field range.
  function automatic int clamp(int v, int top);
    if (v < 0) begin
      return 0;
    end
    if (v > top) begin
      return top;
    end
    return v;
  endfunction

  // Draw one random request: mostly short lines, some full-range, some flat.
  task automatic send_random_line;
    int sx, sy, sz, ex, ey, ez, kind, span;
    begin
      sx = $urandom_range(511);
      sy = $urandom_range(511);
      sz = $urandom_range(63);
      kind = $urandom_range(99);
      if (kind < 55) begin
        span = $urandom_range(1, 3) * 6;
        ex = clamp(sx + $urandom_range(2 * span) - span, 511);
        ey = clamp(sy + $urandom_range(2 * span) - span, 511);
        ez = clamp(sz + $urandom_range(2 * span) - span, 63);
      end else if (kind < 80) begin
        ex = $urandom_range(511);
        ey = $urandom_range(511);
        ez = $urandom_range(63);
      end else begin
        ex = clamp(sx + $urandom_range(40) - 20, 511);
        ey = clamp(sy + $urandom_range(40) - 20, 511);
        ez = clamp(sz + $urandom_range(40) - 20, 63);
        if ($urandom_range(1)) ex = sx;
        if ($urandom_range(1)) ey = sy;
        if ($urandom_range(1)) ez = sz;
      end
      send_line(sx, sy, sz, ex, ey, ez);
    end
  endtask

  // Compare one transferred voxel with the oldest expectation.
  task automatic check_voxel;
    voxel_t want;
    logic [PXY_W-1:0] got_x, got_y;
    logic [PZ_W-1:0] got_z;
    begin
      got_x = m_tdata[PXY_W-1:0];
      got_y = m_tdata[2*PXY_W-1:PXY_W];
      got_z = m_tdata[2*PXY_W+PZ_W-1:2*PXY_W];
      voxels_seen++;
      if (m_tlast) begin
        case (m_tuser)
          CAUSE_END:   runs_end++;
          CAUSE_LIMIT: runs_limit++;
          CAUSE_BOUND: runs_bound++;
          default: ;
        endcase
      end
      if (voxel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected voxel x=%0d y=%0d z=%0d last=%0b cause=%0d",
                   $signed(got_x), $signed(got_y), $signed(got_z), m_tlast, m_tuser);
        end
      end else begin
        want = voxel_q.pop_front();
        if (got_x !== want.x || got_y !== want.y || got_z !== want.z ||
            m_tlast !== want.last || m_tuser !== want.cause) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("voxel mismatch: expected x=%0d y=%0d z=%0d last=%0b cause=%0d",
                     $signed(want.x), $signed(want.y), $signed(want.z), want.last,
                     want.cause);
            $display("                actual   x=%0d y=%0d z=%0d last=%0b cause=%0d",
                     $signed(got_x), $signed(got_y), $signed(got_z), m_tlast, m_tuser);
          end
        end
      end
    end
  endtask

  // Receiver: check each transfer, then choose the next ready level.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      check_voxel();
    end
    if (stall_req) begin
      stall_left = STALL_CYCLES;
      stall_req = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(99) < 37) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Single-voxel runs at both corners of the grid and at one point inside it.
  task automatic test_single_voxel;
    begin
      send_line(0, 0, 0, 0, 0, 0);
      send_line(511, 511, 63, 511, 511, 63);
      send_line(256, 17, 40, 256, 17, 40);
      drain();
    end
  endtask

  // Full diagonals, the length limit, and the end landing on the limit.
  task automatic test_extremes;
    begin
      send_line(0, 0, 0, 511, 511, 63);
      send_line(511, 511, 63, 0, 0, 0);
      send_line(0, 511, 0, 511, 0, 63);
      send_line(0, 0, 0, WALK_MAX - 1, 0, 0);
      send_line(0, 0, 0, WALK_MAX, 0, 0);
      send_line(0, 0, 0, 0, WALK_MAX - 1, 0);
      send_line(0, 0, 0, 0, 0, WALK_MAX - 1);
      send_line(100, 100, 0, 100, 100, 63);
      drain();
    end
  endtask

  // Equal distances exercise the tie order; also walks near the upper edge.
  task automatic test_ties_and_edges;
    begin
      send_line(10, 10, 10, 20, 20, 20);
      send_line(10, 10, 10, 20, 20, 10);
      send_line(10, 10, 10, 10, 20, 20);
      send_line(10, 10, 10, 20, 10, 20);
      send_line(500, 500, 55, 511, 511, 63);
      send_line(505, 0, 60, 511, 9, 63);
      send_line(5, 5, 5, 0, 0, 0);
      send_line(511, 0, 63, 490, 20, 50);
      drain();
    end
  endtask

  // Hold the receiver off while requests keep coming, so the input stalls.
  task automatic test_output_backpressure;
    begin
      stall_req = 1'b1;
      @(posedge clk);
      repeat (8) send_random_line();
      drain();
    end
  endtask

  // Random requests with idling on both sides.
  task automatic test_random_idling(input int n);
    begin
      repeat (n) send_random_line();
      drain();
    end
  endtask

  // Random requests at full rate on both sides.
  task automatic test_random_full_rate(input int n);
    begin
      quiet = 1'b1;
      repeat (n) send_random_line();
      drain();
      quiet = 1'b0;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_voxel();
    test_extremes();
    test_ties_and_edges();
    test_output_backpressure();
    test_random_idling(200);
    test_random_full_rate(90);
    test_random_idling(80);
    $display("Sent %0d line requests and checked %0d voxels.", lines_sent, voxels_seen);
    $display("Runs ended at the end point %0d, at the length limit %0d, at the bound %0d.",
             runs_end, runs_limit, runs_bound);
    if (mismatches == 0 && voxel_q.size() == 0) begin
      $display("[voxel_line_walk_3d] OK");
    end else begin
      $display("[voxel_line_walk_3d] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("[voxel_line_walk_3d] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
